// File: rtl/assert_macros.svh
// assertion macros for the decimator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define TWD_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/twd_pkg.sv
// shared types, constants and helpers for the triangular window decimator
// no dependencies; imported by every other rtl file except assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

package twd_pkg;

   // design constants
   localparam int MAX_RATIO    = 16;
   localparam int SAMPLE_WIDTH = 32;

   // fixed field widths
   localparam int SampleW   = 32;
   localparam int SumW      = 40;
   localparam int RatioW    = 5;
   localparam int SkipW     = 4;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 5;

   // widths that follow from the ratio limit
   localparam int PhaseW = $clog2(MAX_RATIO);
   localparam int RepW   = $clog2(MAX_RATIO + 1);
   localparam int ProdW  = SampleW + RepW + 1;

   // divider: two quotient bits per cycle
   localparam int DivBits   = 2;
   localparam int DivCycles = SumW / DivBits;
   localparam int DivCntW   = $clog2(DivCycles + 1);

   // register indexes
   localparam logic [CsrIndexW-1:0] CSR_RATIO   = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_SKIP    = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_AVERAGE = 2'd2;

   // register reset values
   localparam logic [RatioW-1:0] RATIO_RESET   = 5'd4;
   localparam logic [SkipW-1:0]  SKIP_RESET    = 4'd0;
   localparam logic              AVERAGE_RESET = 1'b1;

   // saturation limits of a row sum
   localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
   localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_ACC,
      ST_DIV_LOAD,
      ST_DIV,
      ST_OUT
   } twd_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic acc;
      logic div_start;
      logic div_step;
      logic out_load;
   } twd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic drop;
      logic emit;
      logic average;
      logic div_done;
      logic out_free;
   } twd_sts_type;

   // clamp a one-bit-wider sum to the row sum range
   function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW:0] v);
      logic signed [SumW-1:0] r;
      if (v[SumW] != v[SumW-1]) begin
         r = v[SumW] ? SumMin : SumMax;
      end else begin
         r = v[SumW-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/twd_if.sv
// valid/ready channel interfaces for the decimator: samples, results, register writes
// depends on twd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface twd_req_if import twd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SampleW-1:0] sample;
   logic                      series_start;

   modport source (output valid, output sample, output series_start, input ready);
   modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface twd_rsp_if import twd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [SumW-1:0] aggregate;

   modport source (output valid, output aggregate, input ready);
   modport sink   (input valid, input aggregate, output ready);
endinterface

interface twd_csr_if import twd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CsrIndexW-1:0] index;
   logic [CsrDataW-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/twd_datapath.sv
// datapath of the decimator: config registers, row sums, radix-4 divider, output register
// depends on twd_pkg; driven by twd_ctrl through twd_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module twd_datapath import twd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  twd_cmd_type               cmd,
   output twd_sts_type               sts,
   input  logic signed [SampleW-1:0] req_sample,
   input  logic                      req_series_start,
   input  logic                      csr_write,
   input  logic [CsrIndexW-1:0]      csr_index,
   input  logic [CsrDataW-1:0]       csr_wdata,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [SumW-1:0]    rsp_aggregate
);

   // configuration registers
   logic [RatioW-1:0] ratio_ff;
   logic [SkipW-1:0]  skip_ff;
   logic              average_ff;

   // series state
   logic [SkipW-1:0]       skip_left_ff, skip_left_in;
   logic [PhaseW-1:0]      phase_ff;
   logic                   seen_ff;
   logic signed [SumW-1:0] older_ff;
   logic signed [SumW-1:0] newer_ff;

   // item registers
   logic signed [SampleW-1:0] sample_ff;
   logic                      start_ff;
   logic [PhaseW-1:0]         p_ff;
   logic signed [ProdW-1:0]   prod_old_ff;
   logic signed [ProdW-1:0]   prod_new_ff;
   logic signed [SumW-1:0]    val_ff;

   // divider registers
   logic              neg_ff;
   logic [SumW-1:0]   num_ff, num_in;
   logic [RepW-1:0]   rem_ff, rem_in;
   logic [DivCntW-1:0] cnt_ff;

   // output register
   logic                   rsp_valid_ff;
   logic signed [SumW-1:0] agg_ff;

   // combinational
   logic [RepW-1:0]           rep;
   logic [SkipW-1:0]          skl;
   logic [PhaseW-1:0]         ph;
   logic [PhaseW-1:0]         p;
   logic [PhaseW-1:0]         w_old;
   logic [RepW-1:0]           w_new;
   logic signed [SampleW-1:0] x;
   logic signed [ProdW-1:0]   prod_old, prod_new;
   logic signed [SumW-1:0]    older_sat, newer_sat;
   logic                      last;
   logic                      drop;
   logic                      emit;
   logic signed [SumW-1:0]    quot;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff   <= RATIO_RESET;
         skip_ff    <= SKIP_RESET;
         average_ff <= AVERAGE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RATIO:   ratio_ff   <= csr_wdata[RatioW-1:0];
            CSR_SKIP:    skip_ff    <= csr_wdata[SkipW-1:0];
            CSR_AVERAGE: average_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective ratio: zero acts as one, large values clamp
   always_comb begin
      if (ratio_ff == '0) begin
         rep = RepW'(1);
      end else if (int'(ratio_ff) > MAX_RATIO) begin
         rep = RepW'(MAX_RATIO);
      end else begin
         rep = RepW'(ratio_ff);
      end
   end

   // step: apply series start, skip, block position and weighted products
   always_comb begin
      skl   = start_ff ? skip_ff : skip_left_ff;
      ph    = start_ff ? '0 : phase_ff;
      drop  = (skl != '0);
      if (RepW'(ph) >= rep) begin
         p = PhaseW'(rep - RepW'(1));
      end else begin
         p = ph;
      end
      w_old = PhaseW'(rep - RepW'(1) - RepW'(p));
      w_new = RepW'(p) + RepW'(1);
      x     = $signed(sample_ff[SAMPLE_WIDTH-1:0]);
      prod_old = $signed({1'b0, w_old}) * x;
      prod_new = $signed({1'b0, w_new}) * x;
      skip_left_in = drop ? (skl - SkipW'(1)) : '0;
   end

   // accumulate: saturating row sums and emit decision
   always_comb begin
      older_sat = sat_sum((SumW+1)'(older_ff) + (SumW+1)'(prod_old_ff));
      newer_sat = sat_sum((SumW+1)'(newer_ff) + (SumW+1)'(prod_new_ff));
      last      = (RepW'(p_ff) == rep - RepW'(1));
      emit      = (rep == RepW'(1)) || ((RepW'(p_ff) == rep - RepW'(2)) && seen_ff);
   end

   // series state and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_left_ff <= '0;
         phase_ff     <= '0;
         seen_ff      <= 1'b0;
         older_ff     <= '0;
         newer_ff     <= '0;
      end else if (cmd.step) begin
         skip_left_ff <= skip_left_in;
         if (start_ff) begin
            phase_ff <= '0;
            seen_ff  <= 1'b0;
            older_ff <= '0;
            newer_ff <= '0;
         end
      end else if (cmd.acc) begin
         if (last) begin
            older_ff <= newer_sat;
            newer_ff <= '0;
            phase_ff <= '0;
            seen_ff  <= 1'b1;
         end else begin
            older_ff <= older_sat;
            newer_ff <= newer_sat;
            phase_ff <= p_ff + PhaseW'(1);
         end
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
         start_ff  <= req_series_start;
      end
      if (cmd.step) begin
         p_ff        <= p;
         prod_old_ff <= prod_old;
         prod_new_ff <= prod_new;
      end
      if (cmd.acc) begin
         val_ff <= (rep == RepW'(1)) ? newer_sat : older_sat;
      end
   end

   // two restoring division steps per cycle on the magnitude
   always_comb begin
      logic [RepW:0] trial;
      num_in = num_ff;
      rem_in = rem_ff;
      for (int i = 0; i < DivBits; i++) begin
         trial  = {rem_in, num_in[SumW-1]};
         num_in = {num_in[SumW-2:0], 1'b0};
         if (trial >= (RepW+1)'(rep)) begin
            rem_in    = RepW'(trial - (RepW+1)'(rep));
            num_in[0] = 1'b1;
         end else begin
            rem_in = RepW'(trial);
         end
      end
   end

   // divider counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= DivCntW'(DivCycles);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - DivCntW'(1);
      end
   end

   // divider operands
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= val_ff[SumW-1];
         num_ff <= val_ff[SumW-1] ? SumW'(-val_ff) : SumW'(val_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   // quotient with the dividend's sign, truncating toward zero
   assign quot = neg_ff ? -$signed(num_ff) : $signed(num_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         agg_ff <= average_ff ? quot : val_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_aggregate = agg_ff;

   // status back to the controller
   always_comb begin
      sts.drop     = drop;
      sts.emit     = emit;
      sts.average  = average_ff;
      sts.div_done = (cnt_ff == '0);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// File: rtl/twd_ctrl.sv
// controller of the decimator: sequences capture, step, accumulate, divide and output
// depends on twd_pkg and assert_macros.svh; drives twd_datapath through twd_cmd_type
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module twd_ctrl import twd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  twd_sts_type sts,
   output twd_cmd_type cmd
);

   twd_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = sts.drop ? ST_IDLE : ST_ACC;
         end
         ST_ACC: begin
            if (!sts.emit) begin
               state_in = ST_IDLE;
            end else begin
               state_in = sts.average ? ST_DIV_LOAD : ST_OUT;
            end
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_STEP:     cmd.step      = 1'b1;
         ST_ACC:      cmd.acc       = 1'b1;
         ST_DIV_LOAD: cmd.div_start = 1'b1;
         ST_DIV:      cmd.div_step  = !sts.div_done;
         ST_OUT:      cmd.out_load  = sts.out_free;
         default: ;
      endcase
   end

   // checks
   `TWD_ASSERT(a_accept_starts_step, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_STEP), "accepted sample did not start a step")
   `TWD_ASSERT(a_no_emit_frees_input, clock, reset, (state_ff == ST_ACC && !sts.emit) |=> req_ready, "input not freed after a silent sample")
   `TWD_ASSERT(a_div_done_to_out, clock, reset, (state_ff == ST_DIV && sts.div_done) |=> (state_ff == ST_OUT), "finished division did not reach output")

endmodule

`default_nettype wire

// File: rtl/triangular_window_decimator_unit.sv
// Triangular window decimator (second-order CIC decimation by a configured ratio).
// Channels: req_bus carries one signed 32-bit sample and a series_start flag per
// transfer; rsp_bus carries one 40-bit aggregate per completed output row; csr_bus
// writes ratio (index 0), skip (index 1) and average_mode (index 2), always ready.
// One sample is processed at a time. A skipped sample passes from the step state back to
// idle, a sample that completes no row passes through step and accumulate; a row in
// raw-sum mode passes through step, accumulate and output, plus any wait for the output
// register; in averaging mode the divider load and divide states come between accumulate
// and output, with two quotient bits per divide step over the 40-bit magnitude. The result
// appears on rsp_bus the cycle after the output state. The output register lets the next
// sample be taken while a result waits; if the receiver stalls and a second result is
// ready, the controller holds in its output state until the register frees.
// Reset (synchronous, active high) restores ratio 4, skip 0, averaging on, and
// clears all series state; samples before any series start form a series with no skip.
// Depends on twd_pkg, twd_if, twd_ctrl and twd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module triangular_window_decimator_unit import twd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   twd_req_if.sink      req_bus,
   twd_rsp_if.source    rsp_bus,
   twd_csr_if.sink      csr_bus
);

   twd_cmd_type cmd;
   twd_sts_type sts;
   logic        csr_write;

   // register writes are always accepted
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   // controller
   twd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   twd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_sample       (req_bus.sample),
      .req_series_start (req_bus.series_start),
      .csr_write        (csr_write),
      .csr_index        (csr_bus.index),
      .csr_wdata        (csr_bus.wdata),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_aggregate    (rsp_bus.aggregate)
   );

endmodule

`default_nettype wire
